>>> sv/microsecond_timer_alarms_watchdog_core_assert.svh
`ifndef MICROSECOND_TIMER_ALARMS_WATCHDOG_CORE_ASSERT_SVH
`define MICROSECOND_TIMER_ALARMS_WATCHDOG_CORE_ASSERT_SVH

// same-cycle implication
`define MTAW_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTAW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mtaw_pkg.sv
package mtaw_pkg;

    localparam int NUM_ALARMS_DEF    = 4;
    localparam int SCRATCH_WORDS_DEF = 8;

    typedef enum logic [1:0]
    {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    localparam logic BLK_TIMER = 1'b0;
    localparam logic BLK_WDOG  = 1'b1;

    localparam logic [4:0] TW_HIGH      = 5'd0;
    localparam logic [4:0] TW_LOW       = 5'd1;
    localparam logic [4:0] TW_LATCHED   = 5'd2;
    localparam logic [4:0] TW_LOW_LATCH = 5'd3;
    localparam logic [4:0] TW_ALARM0    = 5'd4;
    localparam logic [4:0] TW_ARMED     = 5'd8;
    localparam logic [4:0] TW_HIGH_RO   = 5'd9;
    localparam logic [4:0] TW_LOW_RO    = 5'd10;
    localparam logic [4:0] TW_DBG_PAUSE = 5'd11;
    localparam logic [4:0] TW_PAUSE     = 5'd12;
    localparam logic [4:0] TW_RAW       = 5'd13;
    localparam logic [4:0] TW_ENABLE    = 5'd14;
    localparam logic [4:0] TW_FORCE     = 5'd15;
    localparam logic [4:0] TW_STATUS    = 5'd16;

    localparam logic [4:0] WW_CONTROL    = 5'd0;
    localparam logic [4:0] WW_LOAD       = 5'd1;
    localparam logic [4:0] WW_REASON     = 5'd2;
    localparam logic [4:0] WW_SCRATCH0   = 5'd3;
    localparam logic [4:0] WW_TICK_SETUP = 5'd11;

    localparam int WD_ENABLE_BIT  = 30;
    localparam int WD_TRIGGER_BIT = 31;
    localparam int TS_EXT_BIT     = 9;

    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_EXPIRED = 2'd1;
    localparam logic [1:0] REASON_TRIGGER = 2'd2;

    typedef struct packed
    {
        op_t         op;
        logic        blk;
        logic [4:0]  word;
        logic [31:0] data;
    } item_t;

    typedef struct packed
    {
        logic        en;
        logic [63:0] count_now;
        logic [63:0] count_chk;
    } chk_t;

endpackage

>>> sv/mtaw_timer.sv
module mtaw_timer #(
    parameter int NUM_ALARMS = mtaw_pkg::NUM_ALARMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                proc,
    input  mtaw_pkg::item_t     item,
    output mtaw_pkg::chk_t      chk,
    output logic [31:0]         rdata,
    output logic [3:0]          irq_next
);

    localparam int AIW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam logic [4:0] ALARM_END = 5'(int'(mtaw_pkg::TW_ALARM0) + NUM_ALARMS);

    logic [63:0]           count_reg, count_next;
    logic [31:0]           latched_high_reg, latched_high_next;
    logic [31:0]           target_reg [NUM_ALARMS];
    logic [31:0]           target_next [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] armed_reg, armed_next;
    logic [NUM_ALARMS-1:0] raw_reg, raw_next;
    logic [NUM_ALARMS-1:0] en_reg, en_next;
    logic [NUM_ALARMS-1:0] force_reg, force_next;
    logic [31:0]           debug_pause_reg, debug_pause_next;
    logic [31:0]           pause_reg, pause_next;

    logic                  is_tick, is_rd, is_wr, alarm_sel, alarm_wr, check_en;
    logic [AIW-1:0]        alarm_idx;
    logic [63:0]           count_chk;
    logic [NUM_ALARMS-1:0] fire;
    logic [31:0]           diff;

    always_comb
    begin
        is_tick   = (item.op == mtaw_pkg::OP_TICK);
        is_rd     = (item.op == mtaw_pkg::OP_READ) && (item.blk == mtaw_pkg::BLK_TIMER);
        is_wr     = (item.op == mtaw_pkg::OP_WRITE) && (item.blk == mtaw_pkg::BLK_TIMER);
        alarm_sel = (item.word >= mtaw_pkg::TW_ALARM0) && (item.word < ALARM_END);
        alarm_idx = AIW'(item.word - mtaw_pkg::TW_ALARM0);
        alarm_wr  = is_wr && alarm_sel;
        count_chk = is_tick ? count_reg + 64'd1 : count_reg;
        check_en  = (is_tick || alarm_wr) && (pause_reg == 32'd0);

        count_next        = count_chk;
        latched_high_next = latched_high_reg;
        target_next       = target_reg;
        armed_next        = armed_reg;
        raw_next          = raw_reg;
        en_next           = en_reg;
        force_next        = force_reg;
        debug_pause_next  = debug_pause_reg;
        pause_next        = pause_reg;
        rdata             = 32'd0;

        if (alarm_wr)
        begin
            target_next[alarm_idx] = item.data;
            armed_next[alarm_idx]  = 1'b1;
        end

        for (int k = 0; k < NUM_ALARMS; k++)
        begin
            diff    = count_chk[31:0] - target_next[k];
            fire[k] = check_en && armed_next[k] && !diff[31];
        end
        armed_next = armed_next & ~fire;
        raw_next   = raw_next | fire;

        if (is_wr)
        begin
            unique case (item.word)
                mtaw_pkg::TW_HIGH:      count_next = {item.data, count_reg[31:0]};
                mtaw_pkg::TW_LOW:       count_next = {count_reg[63:32], item.data};
                mtaw_pkg::TW_ARMED:     armed_next = armed_reg & ~item.data[NUM_ALARMS-1:0];
                mtaw_pkg::TW_DBG_PAUSE: debug_pause_next = item.data;
                mtaw_pkg::TW_PAUSE:     pause_next = item.data;
                mtaw_pkg::TW_RAW:       raw_next = raw_reg & ~item.data[NUM_ALARMS-1:0];
                mtaw_pkg::TW_ENABLE:    en_next = item.data[NUM_ALARMS-1:0];
                mtaw_pkg::TW_FORCE:     force_next = item.data[NUM_ALARMS-1:0];
                default:                ;
            endcase
        end

        if (is_rd)
        begin
            unique case (item.word)
                mtaw_pkg::TW_HIGH,
                mtaw_pkg::TW_HIGH_RO:   rdata = count_reg[63:32];
                mtaw_pkg::TW_LOW,
                mtaw_pkg::TW_LOW_RO:    rdata = count_reg[31:0];
                mtaw_pkg::TW_LATCHED:   rdata = latched_high_reg;
                mtaw_pkg::TW_LOW_LATCH:
                begin
                    rdata             = count_reg[31:0];
                    latched_high_next = count_reg[63:32];
                end
                mtaw_pkg::TW_ARMED:     rdata = 32'(armed_reg);
                mtaw_pkg::TW_DBG_PAUSE: rdata = debug_pause_reg;
                mtaw_pkg::TW_PAUSE:     rdata = pause_reg;
                mtaw_pkg::TW_RAW:       rdata = 32'(raw_reg);
                mtaw_pkg::TW_ENABLE:    rdata = 32'(en_reg);
                mtaw_pkg::TW_FORCE:     rdata = 32'(force_reg);
                mtaw_pkg::TW_STATUS:    rdata = 32'((raw_reg | force_reg) & en_reg);
                default:
                begin
                    if (alarm_sel)
                    begin
                        rdata = target_reg[alarm_idx];
                    end
                end
            endcase
        end

        irq_next      = 4'((raw_next | force_next) & en_next);
        chk.en        = proc && check_en;
        chk.count_now = count_reg;
        chk.count_chk = count_chk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= 64'd0;
            latched_high_reg <= 32'd0;
            for (int k = 0; k < NUM_ALARMS; k++)
            begin
                target_reg[k] <= 32'd0;
            end
            armed_reg        <= '0;
            raw_reg          <= '0;
            en_reg           <= '0;
            force_reg        <= '0;
            debug_pause_reg  <= 32'd0;
            pause_reg        <= 32'd0;
        end
        else if (proc && (item.op == mtaw_pkg::OP_TICK || item.blk == mtaw_pkg::BLK_TIMER))
        begin
            count_reg        <= count_next;
            latched_high_reg <= latched_high_next;
            target_reg       <= target_next;
            armed_reg        <= armed_next;
            raw_reg          <= raw_next;
            en_reg           <= en_next;
            force_reg        <= force_next;
            debug_pause_reg  <= debug_pause_next;
            pause_reg        <= pause_next;
        end
    end

endmodule

>>> sv/mtaw_wdog.sv
module mtaw_wdog #(
    parameter int SCRATCH_WORDS = mtaw_pkg::SCRATCH_WORDS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            proc,
    input  mtaw_pkg::item_t item,
    input  mtaw_pkg::chk_t  chk,
    output logic [31:0]     rdata,
    output logic            rst_out
);

    localparam int SIW = (SCRATCH_WORDS > 1) ? $clog2(SCRATCH_WORDS) : 1;
    localparam logic [4:0] SCRATCH_END =
        5'(int'(mtaw_pkg::WW_SCRATCH0) + SCRATCH_WORDS);

    logic [31:0]    control_reg, control_next;
    logic [23:0]    load_reg, load_next;
    logic [1:0]     reason_reg, reason_next;
    logic [31:0]    scratch_reg [SCRATCH_WORDS];
    logic [31:0]    scratch_next [SCRATCH_WORDS];
    logic [31:0]    tick_setup_reg, tick_setup_next;
    logic [63:0]    deadline_reg, deadline_next;

    logic           is_rd, is_wr, scratch_sel;
    logic [SIW-1:0] scratch_idx;

    always_comb
    begin
        is_rd       = (item.op == mtaw_pkg::OP_READ) && (item.blk == mtaw_pkg::BLK_WDOG);
        is_wr       = (item.op == mtaw_pkg::OP_WRITE) && (item.blk == mtaw_pkg::BLK_WDOG);
        scratch_sel = (item.word >= mtaw_pkg::WW_SCRATCH0) && (item.word < SCRATCH_END);
        scratch_idx = SIW'(item.word - mtaw_pkg::WW_SCRATCH0);

        control_next    = control_reg;
        load_next       = load_reg;
        reason_next     = reason_reg;
        scratch_next    = scratch_reg;
        tick_setup_next = tick_setup_reg;
        deadline_next   = deadline_reg;
        rdata           = 32'd0;
        rst_out         = 1'b0;

        if (is_wr)
        begin
            unique case (item.word)
                mtaw_pkg::WW_CONTROL:
                begin
                    control_next = item.data;
                    if (item.data[mtaw_pkg::WD_TRIGGER_BIT])
                    begin
                        reason_next = mtaw_pkg::REASON_TRIGGER;
                        rst_out     = 1'b1;
                    end
                    deadline_next = item.data[mtaw_pkg::WD_ENABLE_BIT]
                                  ? chk.count_now + 64'(load_reg[23:1]) : 64'd0;
                end
                mtaw_pkg::WW_LOAD:
                begin
                    load_next = item.data[23:0];
                    if (control_reg[mtaw_pkg::WD_ENABLE_BIT])
                    begin
                        deadline_next = chk.count_now + 64'(item.data[23:1]);
                    end
                end
                mtaw_pkg::WW_REASON:     reason_next = mtaw_pkg::REASON_NONE;
                mtaw_pkg::WW_TICK_SETUP: tick_setup_next = item.data;
                default:
                begin
                    if (scratch_sel)
                    begin
                        scratch_next[scratch_idx] = item.data;
                    end
                end
            endcase
        end

        if (chk.en && control_reg[mtaw_pkg::WD_ENABLE_BIT] && (deadline_reg != 64'd0)
            && (chk.count_chk >= deadline_reg))
        begin
            deadline_next = 64'd0;
            reason_next   = mtaw_pkg::REASON_EXPIRED;
            rst_out       = 1'b1;
        end

        if (is_rd)
        begin
            unique case (item.word)
                mtaw_pkg::WW_CONTROL:    rdata = control_reg;
                mtaw_pkg::WW_LOAD:       rdata = 32'(load_reg);
                mtaw_pkg::WW_REASON:     rdata = 32'(reason_reg);
                mtaw_pkg::WW_TICK_SETUP:
                begin
                    rdata = {21'd0, {2{tick_setup_reg[mtaw_pkg::TS_EXT_BIT]}},
                             tick_setup_reg[8:0]};
                end
                default:
                begin
                    if (scratch_sel)
                    begin
                        rdata = scratch_reg[scratch_idx];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= 32'd0;
            load_reg       <= 24'd0;
            reason_reg     <= mtaw_pkg::REASON_NONE;
            for (int k = 0; k < SCRATCH_WORDS; k++)
            begin
                scratch_reg[k] <= 32'd0;
            end
            tick_setup_reg <= 32'd0;
            deadline_reg   <= 64'd0;
        end
        else if (proc)
        begin
            control_reg    <= control_next;
            load_reg       <= load_next;
            reason_reg     <= reason_next;
            scratch_reg    <= scratch_next;
            tick_setup_reg <= tick_setup_next;
            deadline_reg   <= deadline_next;
        end
    end

endmodule

>>> sv/microsecond_timer_alarms_watchdog_core.sv
// Microsecond timer with compare alarms and a watchdog.
// Input stream: one transfer per item, either a one-microsecond tick or a
// register read or write to the timer or watchdog space. tuser carries the
// opcode and the target block, tdata the word index and the write data.
// Output stream: exactly one transfer per input item, in order, carrying the
// read data, the four interrupt lines and the machine reset flag.
// Path: an accepted item waits in the input register, is processed, and its
// result is offered from the result register.
// Throughput: one item per cycle while the output is taken. The whole item,
// with the 64-bit tick increment, parallel alarm compares and 64-bit deadline
// compare, resolves combinationally between the input and result registers.
// Reset: counter, alarms, masks, watchdog state and scratch words clear to
// zero; both registers empty. The machine reset output is only a flag in the
// result and does not clear any state here.
// Stall: while the output is not taken the result register holds, the input
// register takes one more item if it is empty, then s_axis_tready drops.
`include "microsecond_timer_alarms_watchdog_core_assert.svh"

module microsecond_timer_alarms_watchdog_core #(
    parameter int NUM_ALARMS    = mtaw_pkg::NUM_ALARMS_DEF,
    parameter int SCRATCH_WORDS = mtaw_pkg::SCRATCH_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // word_index, write_data, zero pad
    input  logic [2:0]  s_axis_tuser,   // opcode, target_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data, irq_lines, machine_reset, zero pad
);

    logic            in_valid_reg;
    mtaw_pkg::item_t in_item_reg;
    logic            out_valid_reg;
    logic [31:0]     out_rdata_reg;
    logic [3:0]      out_irq_reg;
    logic            out_rst_reg;

    logic            proc;
    mtaw_pkg::item_t in_item;
    mtaw_pkg::chk_t  chk;
    logic [31:0]     tm_rdata, wd_rdata;
    logic [3:0]      irq_next;
    logic            wd_rst;

    assign proc          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_rst_reg, out_irq_reg, out_rdata_reg};

    always_comb
    begin
        in_item.op   = mtaw_pkg::op_t'(s_axis_tuser[1:0]);
        in_item.blk  = s_axis_tuser[2];
        in_item.word = s_axis_tdata[4:0];
        in_item.data = s_axis_tdata[36:5];
    end

    mtaw_timer #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_timer (
        .clk      (clk),
        .rst_n    (rst_n),
        .proc     (proc),
        .item     (in_item_reg),
        .chk      (chk),
        .rdata    (tm_rdata),
        .irq_next (irq_next)
    );

    mtaw_wdog #(
        .SCRATCH_WORDS (SCRATCH_WORDS)
    ) u_wdog (
        .clk     (clk),
        .rst_n   (rst_n),
        .proc    (proc),
        .item    (in_item_reg),
        .chk     (chk),
        .rdata   (wd_rdata),
        .rst_out (wd_rst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item;
        end
        if (proc)
        begin
            out_rdata_reg <= (in_item_reg.blk == mtaw_pkg::BLK_WDOG) ? wd_rdata : tm_rdata;
            out_irq_reg   <= irq_next;
            out_rst_reg   <= wd_rst;
        end
    end

    `MTAW_ASSERT_NEXT(a_proc_fills_out, clk, rst_n, proc, out_valid_reg,
        "processed item left no result")
    `MTAW_ASSERT_NEXT(a_in_holds, clk, rst_n, in_valid_reg && !proc,
        in_valid_reg && $stable(in_item_reg), "held input item lost or changed")
    `MTAW_ASSERT_IMPL(a_rst_source, clk, rst_n, proc && wd_rst,
        in_item_reg.op == mtaw_pkg::OP_TICK || in_item_reg.op == mtaw_pkg::OP_WRITE,
        "machine reset raised by a read or unused opcode")
    `MTAW_ASSERT_NEXT(a_rdata_zero, clk, rst_n, proc && in_item_reg.op != mtaw_pkg::OP_READ,
        out_rdata_reg == 32'd0, "read data nonzero on a non-read item")

endmodule

>>> bench/timer_alarm_checker.sv
module timer_alarm_checker
    import mtaw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // word_index, write_data, zero pad
    input  logic [2:0]  s_axis_tuser,   // opcode, target_block
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // read_data, irq_lines, machine_reset, zero pad
    output int          mismatches,
    output int          outstanding
);

    localparam int AW = (NUM_ALARMS_DEF > 1) ? $clog2(NUM_ALARMS_DEF) : 1;
    localparam int SW = (SCRATCH_WORDS_DEF > 1) ? $clog2(SCRATCH_WORDS_DEF) : 1;

    typedef struct packed
    {
        logic [31:0] read_data;
        logic [3:0]  irq_lines;
        logic        machine_reset;
    } result_t;

    result_t     pending_results[$];
    result_t     observed;
    result_t     wanted;
    int          result_no;

    logic [63:0] now_us;
    logic [63:0] deadline_us;
    logic [31:0] hold_high;
    logic [31:0] dbg_pause;
    logic [31:0] pause_reg;
    logic [31:0] wd_control;
    logic [31:0] setup_reg;
    logic [31:0] alarm_at [NUM_ALARMS_DEF];
    logic [31:0] scratch [SCRATCH_WORDS_DEF];
    logic [3:0]  armed;
    logic [3:0]  irq_raw;
    logic [3:0]  irq_en;
    logic [3:0]  irq_force;
    logic [23:0] wd_load;
    logic [1:0]  wd_reason;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got 0x%08h expected 0x%08h", result_no, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_state();
        int k;
        now_us      = '0;
        deadline_us = '0;
        hold_high   = '0;
        dbg_pause   = '0;
        pause_reg   = '0;
        wd_control  = '0;
        setup_reg   = '0;
        armed       = '0;
        irq_raw     = '0;
        irq_en      = '0;
        irq_force   = '0;
        wd_load     = '0;
        wd_reason   = REASON_NONE;
        for (k = 0; k < NUM_ALARMS_DEF; k++)
            alarm_at[k] = '0;
        for (k = 0; k < SCRATCH_WORDS_DEF; k++)
            scratch[k] = '0;
    endfunction

    function automatic logic [3:0] irq_view();
        return (irq_raw | irq_force) & irq_en;
    endfunction

    // unless paused, compare armed alarms, then see whether the watchdog deadline has passed
    function automatic logic sweep_alarms_and_watchdog();
        int          k;
        logic [31:0] diff;
        if (pause_reg != '0)
            return 1'b0;
        for (k = 0; k < NUM_ALARMS_DEF; k++)
        begin
            diff = now_us[31:0] - alarm_at[k];
            if (armed[k] && diff < 32'h8000_0000)
            begin
                armed[k]   = 1'b0;
                irq_raw[k] = 1'b1;
            end
        end
        if (wd_control[WD_ENABLE_BIT] && deadline_us != '0 && now_us >= deadline_us)
        begin
            deadline_us = '0;
            wd_reason   = REASON_EXPIRED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] read_timer(input logic [4:0] w);
        case (w)
            TW_HIGH, TW_HIGH_RO: return now_us[63:32];
            TW_LOW, TW_LOW_RO:   return now_us[31:0];
            TW_LATCHED:          return hold_high;
            TW_LOW_LATCH:
            begin
                hold_high = now_us[63:32];
                return now_us[31:0];
            end
            TW_ARMED:            return {28'd0, armed};
            TW_DBG_PAUSE:        return dbg_pause;
            TW_PAUSE:            return pause_reg;
            TW_RAW:              return {28'd0, irq_raw};
            TW_ENABLE:           return {28'd0, irq_en};
            TW_FORCE:            return {28'd0, irq_force};
            TW_STATUS:           return {28'd0, irq_view()};
            default:
            begin
                if (w >= TW_ALARM0 && w < TW_ALARM0 + NUM_ALARMS_DEF)
                    return alarm_at[AW'(w - TW_ALARM0)];
                return '0;
            end
        endcase
    endfunction

    function automatic logic write_timer(input logic [4:0] w, input logic [31:0] v);
        case (w)
            TW_HIGH:      now_us[63:32] = v;
            TW_LOW:       now_us[31:0]  = v;
            TW_ARMED:     armed     = armed & ~v[3:0];
            TW_DBG_PAUSE: dbg_pause = v;
            TW_PAUSE:     pause_reg = v;
            TW_RAW:       irq_raw   = irq_raw & ~v[3:0];
            TW_ENABLE:    irq_en    = v[3:0];
            TW_FORCE:     irq_force = v[3:0];
            default:
            begin
                if (w >= TW_ALARM0 && w < TW_ALARM0 + NUM_ALARMS_DEF)
                begin
                    alarm_at[AW'(w - TW_ALARM0)] = v;
                    armed[AW'(w - TW_ALARM0)]    = 1'b1;
                    return sweep_alarms_and_watchdog();
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [31:0] read_wdog(input logic [4:0] w);
        logic [31:0] r;
        case (w)
            WW_CONTROL:    return wd_control;
            WW_LOAD:       return {8'd0, wd_load};
            WW_REASON:     return {30'd0, wd_reason};
            WW_TICK_SETUP:
            begin
                r = {23'd0, setup_reg[8:0]};
                if (setup_reg[TS_EXT_BIT])
                    r[10:9] = 2'b11;
                return r;
            end
            default:
            begin
                if (w >= WW_SCRATCH0 && w < WW_SCRATCH0 + SCRATCH_WORDS_DEF)
                    return scratch[SW'(w - WW_SCRATCH0)];
                return '0;
            end
        endcase
    endfunction

    function automatic logic write_wdog(input logic [4:0] w, input logic [31:0] v);
        logic hit;
        hit = 1'b0;
        case (w)
            WW_CONTROL:
            begin
                wd_control = v;
                if (v[WD_TRIGGER_BIT])
                begin
                    wd_reason = REASON_TRIGGER;
                    hit       = 1'b1;
                end
                deadline_us = v[WD_ENABLE_BIT] ? now_us + 64'(wd_load >> 1) : 64'd0;
            end
            WW_LOAD:
            begin
                wd_load = v[23:0];
                if (wd_control[WD_ENABLE_BIT])
                    deadline_us = now_us + 64'(wd_load >> 1);
            end
            WW_REASON:     wd_reason = REASON_NONE;
            WW_TICK_SETUP: setup_reg = v;
            default:
            begin
                if (w >= WW_SCRATCH0 && w < WW_SCRATCH0 + SCRATCH_WORDS_DEF)
                    scratch[SW'(w - WW_SCRATCH0)] = v;
            end
        endcase
        return hit;
    endfunction

    function automatic result_t apply_item(input logic [1:0] op, input logic blk,
                                           input logic [4:0] w, input logic [31:0] v);
        result_t res;
        res = '0;
        if (op == OP_TICK)
        begin
            now_us            = now_us + 64'd1;
            res.machine_reset = sweep_alarms_and_watchdog();
        end
        else if (op == OP_READ)
            res.read_data = (blk == BLK_WDOG) ? read_wdog(w) : read_timer(w);
        else if (op == OP_WRITE)
            res.machine_reset = (blk == BLK_WDOG) ? write_wdog(w, v) : write_timer(w, v);
        res.irq_lines = irq_view();
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            pending_results.delete();
            result_no  = 0;
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed = {m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tdata[36]};
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, read_data", observed.read_data, '0);
                else
                begin
                    wanted = pending_results.pop_front();
                    if (observed.read_data !== wanted.read_data)
                        report_mismatch("read_data", observed.read_data, wanted.read_data);
                    if (observed.irq_lines !== wanted.irq_lines)
                        report_mismatch("irq_lines", 32'(observed.irq_lines),
                                        32'(wanted.irq_lines));
                    if (observed.machine_reset !== wanted.machine_reset)
                        report_mismatch("machine_reset", 32'(observed.machine_reset),
                                        32'(wanted.machine_reset));
                end
                result_no++;
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(apply_item(s_axis_tuser[1:0], s_axis_tuser[2],
                                                     s_axis_tdata[4:0], s_axis_tdata[36:5]));
        end
        outstanding = pending_results.size();
    end

endmodule

>>> bench/testbench.sv
module testbench;
    import mtaw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 550;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // word_index, write_data, zero pad
    logic [2:0]  s_axis_tuser;   // opcode, target_block
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;   // read_data, irq_lines, machine_reset, zero pad
    logic        steady;
    logic [63:0] stim_count;
    int          mismatches;
    int          outstanding;

    microsecond_timer_alarms_watchdog_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    timer_alarm_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);

    initial
    begin
        #2_000_000;
        $display("microsecond_timer_alarms_watchdog_core: mismatch");
        $finish;
    end

    task automatic issue_access(input logic [1:0] op, input logic blk,
                                input logic [4:0] word, input logic [31:0] data);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {blk, op};
        s_axis_tdata  <= {3'b000, data, word};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // track the counter roughly so alarm targets land near it
        if (op == OP_TICK)
            stim_count = stim_count + 64'd1;
        else if (op == OP_WRITE && blk == BLK_TIMER && word == TW_HIGH)
            stim_count[63:32] = data;
        else if (op == OP_WRITE && blk == BLK_TIMER && word == TW_LOW)
            stim_count[31:0] = data;
    endtask

    task automatic random_access();
        int          pick;
        logic        blk;
        logic [4:0]  word;
        logic [31:0] data;
        pick = $urandom_range(0, 99);
        blk  = 1'($urandom_range(0, 1));
        data = $urandom;
        if (pick < 38)
            issue_access(OP_TICK, blk, 5'($urandom_range(0, 31)), data);
        else if (pick < 50)
        begin
            word = TW_ALARM0 + 5'($urandom_range(0, NUM_ALARMS_DEF - 1));
            if ($urandom_range(0, 3) != 0)
                data = stim_count[31:0] + $urandom_range(0, 40) - 32'd10;
            issue_access(OP_WRITE, BLK_TIMER, word, data);
        end
        else if (pick < 66)
        begin
            if ($urandom_range(0, 9) == 0)
                word = 5'($urandom_range(0, 31));
            else if (blk == BLK_WDOG)
                word = 5'($urandom_range(0, WW_TICK_SETUP));
            else
                word = 5'($urandom_range(0, TW_STATUS));
            issue_access(OP_READ, blk, word, data);
        end
        else if (pick < 72)
        begin
            data[WD_ENABLE_BIT]  = ($urandom_range(0, 99) < 70);
            data[WD_TRIGGER_BIT] = ($urandom_range(0, 99) < 8);
            issue_access(OP_WRITE, BLK_WDOG, WW_CONTROL, data);
        end
        else if (pick < 78)
        begin
            if ($urandom_range(0, 4) != 0)
                data = $urandom_range(0, 60);
            issue_access(OP_WRITE, BLK_WDOG, WW_LOAD, data);
        end
        else if (pick < 82)
            issue_access(OP_WRITE, BLK_WDOG, 5'($urandom_range(WW_REASON, WW_TICK_SETUP)), data);
        else if (pick < 90)
        begin
            case ($urandom_range(0, 3))
                0:       word = TW_ENABLE;
                1:       word = TW_FORCE;
                2:       word = TW_RAW;
                default: word = TW_ARMED;
            endcase
            issue_access(OP_WRITE, BLK_TIMER, word, data);
        end
        else if (pick < 93)
        begin
            if ($urandom_range(0, 99) < 75)
                data = '0;
            word = ($urandom_range(0, 3) == 0) ? TW_DBG_PAUSE : TW_PAUSE;
            issue_access(OP_WRITE, BLK_TIMER, word, data);
        end
        else if (pick < 96)
        begin
            if ($urandom_range(0, 1) == 0)
                data = 32'hFFFF_FFFF - $urandom_range(0, 5);
            word = ($urandom_range(0, 1) == 0) ? TW_HIGH : TW_LOW;
            issue_access(OP_WRITE, BLK_TIMER, word, data);
        end
        else if (pick < 98)
            issue_access(OP_WRITE, blk, 5'($urandom_range(0, 31)), data);
        else
            issue_access(OP_UNUSED, blk, 5'($urandom_range(0, 31)), data);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        steady        = 1'b0;
        stim_count    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue_access(OP_READ,  BLK_TIMER, TW_STATUS,       '0);
        issue_access(OP_WRITE, BLK_TIMER, TW_ENABLE,       32'hFFFF_FFFF);
        issue_access(OP_WRITE, BLK_TIMER, TW_ALARM0,       32'h0000_0000);
        issue_access(OP_WRITE, BLK_TIMER, TW_ALARM0 + 5'd1, 32'h0000_0003);
        issue_access(OP_WRITE, BLK_TIMER, TW_ALARM0 + 5'd2, 32'h8000_0000);
        issue_access(OP_WRITE, BLK_TIMER, TW_ALARM0 + 5'd3, 32'hFFFF_FFFF);
        repeat (3)
            issue_access(OP_TICK, BLK_TIMER, TW_HIGH, '0);
        issue_access(OP_READ,  BLK_TIMER, TW_RAW,          '0);
        issue_access(OP_WRITE, BLK_TIMER, TW_RAW,          32'hFFFF_FFFF);
        issue_access(OP_WRITE, BLK_TIMER, TW_FORCE,        32'h0000_000F);
        issue_access(OP_WRITE, BLK_TIMER, TW_HIGH,         32'hFFFF_FFFF);
        issue_access(OP_WRITE, BLK_TIMER, TW_LOW,          32'hFFFF_FFFE);
        issue_access(OP_TICK,  BLK_WDOG,  5'd31,           32'hFFFF_FFFF);
        issue_access(OP_TICK,  BLK_TIMER, TW_HIGH,         '0);
        issue_access(OP_READ,  BLK_TIMER, TW_LOW_LATCH,    '0);
        issue_access(OP_READ,  BLK_TIMER, TW_LATCHED,      '0);
        issue_access(OP_WRITE, BLK_WDOG,  WW_LOAD,         32'hFFFF_FFFF);
        issue_access(OP_WRITE, BLK_WDOG,  WW_CONTROL,      32'h4000_0000);
        issue_access(OP_WRITE, BLK_WDOG,  WW_LOAD,         32'h0000_0002);
        issue_access(OP_TICK,  BLK_TIMER, TW_HIGH,         '0);
        issue_access(OP_READ,  BLK_WDOG,  WW_REASON,       '0);
        issue_access(OP_WRITE, BLK_WDOG,  WW_CONTROL,      32'hC000_0000);
        issue_access(OP_WRITE, BLK_WDOG,  WW_TICK_SETUP,   32'hFFFF_FFFF);
        issue_access(OP_READ,  BLK_WDOG,  WW_TICK_SETUP,   '0);
        issue_access(OP_WRITE, BLK_TIMER, TW_PAUSE,        32'h0000_0001);
        issue_access(OP_TICK,  BLK_TIMER, TW_HIGH,         '0);
        issue_access(OP_WRITE, BLK_TIMER, TW_PAUSE,        '0);
        issue_access(OP_UNUSED, BLK_WDOG, 5'd31,           32'hFFFF_FFFF);
        issue_access(OP_READ,  BLK_TIMER, 5'd31,           '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 200 && n < 330);
            random_access();
        end
        steady = 1'b0;

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("microsecond_timer_alarms_watchdog_core: match");
        else
            $display("microsecond_timer_alarms_watchdog_core: mismatch");
        $finish;
    end

endmodule
